// ===== design/line_pad_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// line pad filter assertion macros
// shared property forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LINE_PAD_FILTER_UNIT_MACROS_SVH
`define LINE_PAD_FILTER_UNIT_MACROS_SVH

// consequent holds in the same cycle
`define LPF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the next cycle
`define LPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// types, constants and helper functions of the line pad filter
// ----------------------------------------------------------------------------
`default_nettype none

package lpf_pkg;

   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 16;
   localparam int PAD_W     = 5;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int TAB_STOP  = 8;
   localparam int PAD_MAX   = 31;

   localparam logic [CFG_W-1:0]  UNLIMITED  = 16'hFFFF;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PREFIX_CHAR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PREFIX_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUFFIX_CHAR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUFFIX_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LENGTH   = 3'd5;

   typedef logic [2:0] emit_sel_type;

   // what a beat carries and how it moves the line state
   localparam emit_sel_type SEL_BARE   = 3'd0;
   localparam emit_sel_type SEL_PREFIX = 3'd1;
   localparam emit_sel_type SEL_SUFFIX = 3'd2;
   localparam emit_sel_type SEL_CR     = 3'd3;
   localparam emit_sel_type SEL_LF     = 3'd4;
   localparam emit_sel_type SEL_BYTE   = 3'd5;

   typedef struct packed {
      logic         load;
      logic         pad_clear;
      logic         pad_suffix;
      logic         emit;
      emit_sel_type emit_sel;
      logic         last;
      logic         set_hold;
   } lpf_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pad_go;
      logic pad_next_go;
      logic line_zero;
      logic cr_held;
      logic new_eos;
      logic new_lf;
      logic new_cr;
      logic item_eos;
      logic item_lf;
      logic item_cr;
   } lpf_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W:0] sum;
      sum = {1'b0, v} + (CNT_W+1)'(1);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] col_advance(input logic [CNT_W-1:0]  col,
                                                    input logic [BYTE_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, col};
      if (b == CHAR_TAB) begin
         sum = {1'b0, col} + (CNT_W+1)'(TAB_STOP) - (CNT_W+1)'(col % TAB_STOP);
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
         sum = {1'b0, col} + (CNT_W+1)'(1);
      end
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/lpf_req_if.sv =====
// ----------------------------------------------------------------------------
// lpf_req_if
// input byte channel of the line pad filter
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_req_if;
   logic                        valid;
   logic                        ready;
   logic [lpf_pkg::BYTE_W-1:0]  in_byte;
   logic                        end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== design/lpf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpf_rsp_if
// output byte channel of the line pad filter
// ----------------------------------------------------------------------------
`default_nettype none

interface lpf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpf_pkg::BYTE_W-1:0]  out_byte;
   logic                        last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== design/lpf_datapath.sv =====
// ----------------------------------------------------------------------------
// lpf_datapath
// config registers, line state, pad limit checks and the output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_pad_filter_unit_macros.svh"

module lpf_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  lpf_pkg::lpf_cmd_type             cmd,
   output lpf_pkg::lpf_status_type          status,
   input  wire [lpf_pkg::BYTE_W-1:0]        req_in_byte,
   input  wire                              req_end_of_stream,
   input  wire                              rsp_ready,
   output logic                             rsp_valid,
   output logic [lpf_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_last,
   input  wire                              csr_write_enable,
   input  wire [lpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [lpf_pkg::CFG_W-1:0]         csr_data
);

   logic [lpf_pkg::BYTE_W-1:0] prefix_char_ff, suffix_char_ff;
   logic [lpf_pkg::PAD_W-1:0]  prefix_count_ff, suffix_count_ff;
   logic [lpf_pkg::CFG_W-1:0]  max_width_ff, max_length_ff;

   logic [lpf_pkg::BYTE_W-1:0] item_byte_ff, item_byte_in;
   logic                       item_eos_ff, item_eos_in;
   logic [lpf_pkg::CNT_W-1:0]  column_ff, column_in;
   logic [lpf_pkg::CNT_W-1:0]  offset_ff, offset_in;
   logic                       cr_held_ff, cr_held_in;
   logic [lpf_pkg::PAD_W-1:0]  pad_k_ff, pad_k_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lpf_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [lpf_pkg::BYTE_W-1:0] pad_char;
   logic [lpf_pkg::PAD_W-1:0]  pad_raw, pad_count;
   logic [lpf_pkg::CNT_W-1:0]  pad_col_next, pad_off_next;
   logic [lpf_pkg::PAD_W:0]    pad_k_next;
   logic                       out_free;

   // limit check for a pad beat at a given column and offset
   function automatic logic pad_room(input logic [lpf_pkg::CNT_W-1:0] col,
                                     input logic [lpf_pkg::CNT_W-1:0] off,
                                     input logic                      suffix,
                                     input logic                      held,
                                     input logic [lpf_pkg::CFG_W-1:0] max_w,
                                     input logic [lpf_pkg::CFG_W-1:0] max_l);
      logic [lpf_pkg::CNT_W+1:0] need;
      logic                      len_block;
      logic                      width_block;
      // suffix room leaves space for the line end bytes
      need = {2'b00, off} + (lpf_pkg::CNT_W+2)'(suffix) + (lpf_pkg::CNT_W+2)'(suffix & held);
      len_block   = (max_l != lpf_pkg::UNLIMITED) && (need >= {2'b00, max_l});
      width_block = (max_w != lpf_pkg::UNLIMITED) && (col >= max_w);
      return !len_block && !width_block;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pad_char  = cmd.pad_suffix ? suffix_char_ff  : prefix_char_ff;
      pad_raw   = cmd.pad_suffix ? suffix_count_ff : prefix_count_ff;
      pad_count = (pad_raw > lpf_pkg::PAD_W'(lpf_pkg::PAD_MAX)) ?
                  lpf_pkg::PAD_W'(lpf_pkg::PAD_MAX) : pad_raw;
      pad_col_next = lpf_pkg::col_advance(column_ff, pad_char);
      pad_off_next = lpf_pkg::sat_inc(offset_ff);
      pad_k_next   = {1'b0, pad_k_ff} + (lpf_pkg::PAD_W+1)'(1);
   end

   always_comb begin
      status.out_free    = out_free;
      status.pad_go      = (pad_k_ff < pad_count) &&
                           pad_room(column_ff, offset_ff, cmd.pad_suffix, cr_held_ff,
                                    max_width_ff, max_length_ff);
      status.pad_next_go = (pad_k_next < {1'b0, pad_count}) &&
                           pad_room(pad_col_next, pad_off_next, cmd.pad_suffix, cr_held_ff,
                                    max_width_ff, max_length_ff);
      status.line_zero   = (offset_ff == '0);
      status.cr_held     = cr_held_ff;
      status.new_eos     = req_end_of_stream;
      status.new_lf      = !req_end_of_stream && (req_in_byte == lpf_pkg::CHAR_LF);
      status.new_cr      = !req_end_of_stream && (req_in_byte == lpf_pkg::CHAR_CR);
      status.item_eos    = item_eos_ff;
      status.item_lf     = !item_eos_ff && (item_byte_ff == lpf_pkg::CHAR_LF);
      status.item_cr     = !item_eos_ff && (item_byte_ff == lpf_pkg::CHAR_CR);
   end

   always_comb begin
      item_byte_in = item_byte_ff;
      item_eos_in  = item_eos_ff;
      column_in    = column_ff;
      offset_in    = offset_ff;
      cr_held_in   = cr_held_ff;
      pad_k_in     = pad_k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         item_byte_in = req_in_byte;
         item_eos_in  = req_end_of_stream;
      end
      if (cmd.pad_clear) begin
         pad_k_in = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         unique case (cmd.emit_sel)
            lpf_pkg::SEL_BARE: begin
               rsp_byte_in = lpf_pkg::CHAR_CR;
               column_in   = '0;
               offset_in   = pad_off_next;
               cr_held_in  = 1'b0;
            end
            lpf_pkg::SEL_PREFIX, lpf_pkg::SEL_SUFFIX: begin
               rsp_byte_in = pad_char;
               column_in   = pad_col_next;
               offset_in   = pad_off_next;
               pad_k_in    = pad_k_next[lpf_pkg::PAD_W-1:0];
            end
            lpf_pkg::SEL_CR: begin
               rsp_byte_in = lpf_pkg::CHAR_CR;
            end
            lpf_pkg::SEL_LF: begin
               rsp_byte_in = lpf_pkg::CHAR_LF;
               column_in   = '0;
               offset_in   = '0;
               cr_held_in  = 1'b0;
            end
            lpf_pkg::SEL_BYTE: begin
               rsp_byte_in = item_byte_ff;
               column_in   = lpf_pkg::col_advance(column_ff, item_byte_ff);
               offset_in   = pad_off_next;
            end
            default: begin
               rsp_byte_in = item_byte_ff;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // a new CR waits for the next item
      if (cmd.set_hold) begin
         cr_held_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_char_ff  <= lpf_pkg::CHAR_SPACE;
         prefix_count_ff <= '0;
         suffix_char_ff  <= lpf_pkg::CHAR_SPACE;
         suffix_count_ff <= '0;
         max_width_ff    <= lpf_pkg::UNLIMITED;
         max_length_ff   <= lpf_pkg::UNLIMITED;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lpf_pkg::REG_PREFIX_CHAR:  prefix_char_ff  <= csr_data[lpf_pkg::BYTE_W-1:0];
            lpf_pkg::REG_PREFIX_COUNT: prefix_count_ff <= csr_data[lpf_pkg::PAD_W-1:0];
            lpf_pkg::REG_SUFFIX_CHAR:  suffix_char_ff  <= csr_data[lpf_pkg::BYTE_W-1:0];
            lpf_pkg::REG_SUFFIX_COUNT: suffix_count_ff <= csr_data[lpf_pkg::PAD_W-1:0];
            lpf_pkg::REG_MAX_WIDTH:    max_width_ff    <= csr_data;
            lpf_pkg::REG_MAX_LENGTH:   max_length_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         offset_ff    <= '0;
         cr_held_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         offset_ff    <= offset_in;
         cr_held_ff   <= cr_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_eos_ff  <= item_eos_in;
      pad_k_ff     <= pad_k_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   `LPF_ASSERT_SAME(a_emit_into_free_slot, cmd.emit, out_free, "beat overwrote a waiting result")
   `LPF_ASSERT_NEXT(a_lf_restarts_line, cmd.emit && (cmd.emit_sel == lpf_pkg::SEL_LF), (offset_ff == '0) && (column_ff == '0) && !cr_held_ff, "line state not cleared after LF")
   `LPF_ASSERT_SAME(a_pad_within_width, cmd.emit && ((cmd.emit_sel == lpf_pkg::SEL_PREFIX) || (cmd.emit_sel == lpf_pkg::SEL_SUFFIX)) && (max_width_ff != lpf_pkg::UNLIMITED), column_ff < max_width_ff, "pad beat past width limit")
   `LPF_ASSERT_SAME(a_lf_is_last, cmd.emit && (cmd.emit_sel == lpf_pkg::SEL_LF), cmd.last, "LF beat not marked last")

endmodule

`default_nettype wire

// ===== design/lpf_controller.sv =====
// ----------------------------------------------------------------------------
// lpf_controller
// sequences the beats of one item: bare CR, prefix, suffix, CR, LF, byte
// ----------------------------------------------------------------------------
`default_nettype none

module lpf_controller (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  lpf_pkg::lpf_status_type   status,
   output lpf_pkg::lpf_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BARE   = 3'd1;
   localparam logic [2:0] ST_PREFIX = 3'd2;
   localparam logic [2:0] ST_SUFFIX = 3'd3;
   localparam logic [2:0] ST_CR     = 3'd4;
   localparam logic [2:0] ST_LF     = 3'd5;
   localparam logic [2:0] ST_BYTE   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.emit_sel   = lpf_pkg::SEL_BYTE;
      cmd.pad_suffix = (state_ff == ST_SUFFIX);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load      = 1'b1;
               cmd.pad_clear = 1'b1;
               priority if (status.new_eos) begin
                  state_in = status.cr_held ? ST_BARE : ST_IDLE;
               end else if (status.new_lf) begin
                  state_in = status.line_zero ? ST_PREFIX : ST_SUFFIX;
               end else if (status.cr_held) begin
                  state_in = ST_BARE;
               end else if (status.line_zero) begin
                  state_in = ST_PREFIX;
               end else if (status.new_cr) begin
                  cmd.set_hold = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BARE: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lpf_pkg::SEL_BARE;
               cmd.last     = status.item_eos || status.item_cr;
               priority if (status.item_eos) begin
                  state_in = ST_IDLE;
               end else if (status.item_cr) begin
                  cmd.set_hold = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_PREFIX: begin
            if (status.pad_go) begin
               if (status.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = lpf_pkg::SEL_PREFIX;
                  // a held CR sends nothing, so the last pad beat closes the item
                  if (status.item_cr && !status.pad_next_go) begin
                     cmd.last     = 1'b1;
                     cmd.set_hold = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            end else begin
               priority if (status.item_lf) begin
                  cmd.pad_clear = 1'b1;
                  state_in      = ST_SUFFIX;
               end else if (status.item_cr) begin
                  cmd.set_hold = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_SUFFIX: begin
            if (status.pad_go) begin
               if (status.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = lpf_pkg::SEL_SUFFIX;
               end
            end else begin
               state_in = status.cr_held ? ST_CR : ST_LF;
            end
         end
         ST_CR: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lpf_pkg::SEL_CR;
               state_in     = ST_LF;
            end
         end
         ST_LF: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lpf_pkg::SEL_LF;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BYTE: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = lpf_pkg::SEL_BYTE;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/line_pad_filter_unit.sv =====
// ----------------------------------------------------------------------------
// line_pad_filter_unit
// byte stream filter that pads each line with prefix and suffix bytes
// ----------------------------------------------------------------------------
// Each accepted beat is taken in, and its results leave at most one per cycle,
// while the output is not stalled, through a single output register, so a
// plain byte is accepted, then sent. A line start sends each prefix pad byte
// and then closes the run; an LF sends each suffix pad byte, closes the run,
// then sends a CR if held and then the LF. A bare CR is a beat of its own.
// The controller walks one item's beats in turn and takes no new
// item until the last of them is in the output register; a stalled output
// stalls the walk. Configuration may be written whenever no item is in work.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pad_filter_unit (
   input  wire                            clock,
   input  wire                            reset,
   lpf_req_if.sink                        req_chan,
   lpf_rsp_if.source                      rsp_chan,
   input  wire                            csr_write_enable,
   input  wire [lpf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [lpf_pkg::CFG_W-1:0]       csr_data
);

   lpf_pkg::lpf_cmd_type    cmd;
   lpf_pkg::lpf_status_type status;
   logic                    req_ready;

   lpf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_in_byte       (req_chan.in_byte),
      .req_end_of_stream (req_chan.end_of_stream),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_out_byte      (rsp_chan.out_byte),
      .rsp_last          (rsp_chan.last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
